>>> hw/rtl/fba_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types for the block allocator.
package fba_pkg;

  localparam int DBLK_TOTAL      = 4096;
  localparam int FILE_SLOTS      = 128;
  localparam int BLOCKS_PER_FILE = 32;
  localparam int BLOCK_BYTES     = 8192;

  localparam int SIZE_W  = 24;
  localparam int SLOT_W  = $clog2(FILE_SLOTS);
  localparam int BLK_W   = $clog2(DBLK_TOTAL);
  localparam int BYTES_W = $clog2(BLOCK_BYTES) + 1;
  localparam int FREE_W  = $clog2(DBLK_TOTAL) + 1;
  localparam int CNT_W   = $clog2(BLOCKS_PER_FILE) + 1;
  localparam int BB_SH   = $clog2(BLOCK_BYTES);
  localparam int NEED_W  = SIZE_W - BB_SH + 1;

  // bitmap word organisation
  localparam int WORD_W   = 32;
  localparam int BM_WORDS = DBLK_TOTAL / WORD_W;
  localparam int BM_AW    = $clog2(BM_WORDS);
  localparam int BIT_W    = $clog2(WORD_W);

  // free slot search groups
  localparam int GRP_W  = 16;
  localparam int GRP_N  = FILE_SLOTS / GRP_W;
  localparam int GRP_AW = $clog2(GRP_N);
  localparam int GRP_BW = $clog2(GRP_W);

  localparam int LIST_AW = SLOT_W + $clog2(BLOCKS_PER_FILE);

  typedef enum logic [1:0] {
    ACT_STORE  = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_NOSLOT  = 3'd2,
    ST_TOOBIG  = 3'd3,
    ST_UNUSED  = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_SCAN,
    OP_WORD_RD,
    OP_WORD_LOAD,
    OP_ALLOC,
    OP_WORD_NEXT,
    OP_COMMIT,
    OP_META_RD,
    OP_META_LATCH,
    OP_LIST_RD,
    OP_EMIT_LIST,
    OP_EMIT_ONE,
    OP_DBLK_RD,
    OP_DBLK_CLR,
    OP_DEL_END
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic    clr_last;
    logic    scan_last;
    logic    slot_found;
    logic    slot_busy;
    logic    over_free;
    logic    over_limit;
    logic    word_full;
    logic    alloc_done;
    logic    list_empty;
    logic    list_last;
    logic    list_end;
    logic    out_free;
    action_t act;
  } dp_stat_t;

endpackage

>>> hw/rtl/file_block_allocator_core.sv
`timescale 1ns / 1ps
// File block allocator: bitmap first-fit allocation of data blocks to file slots.
//
// Input channel (in_valid/in_ready): one beat carries action, file_size and slot.
// Store allocates the lowest free slot and lowest free blocks, delete frees a slot
// and its blocks, read lists the blocks a slot holds. Action 3 gives no result.
// Output channel (out_valid/out_ready): one beat per block, or a single beat for a
// rejection, delete, empty file or unused slot; last marks the final beat.
// Every beat reports the free block count after the request.
// One request is worked on at a time; in_ready is high only while idle.
// Store runs the slot search and checks, allocates blocks one by one, reading and
// writing back each bitmap word visited, commits, then emits a beat per block.
// Read and delete fetch the slot record; delete then clears each listed block's
// bitmap bit. A rejection or unused slot gives its beat after the checks.
// The bitmap memory (one read and one write port) sets the pace of allocation.
// After reset the bitmap is cleared word by word, all 128 words, with in_ready low.
// A stalled receiver holds the output register; the block waits before the next
// beat and, after the last beat, may already accept the next request.
module file_block_allocator_core import fba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          action,
  input  logic [SIZE_W-1:0]   file_size,
  input  logic [SLOT_W-1:0]   slot,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic [SLOT_W-1:0]   slot_out,
  output logic [BLK_W-1:0]    block,
  output logic [BYTES_W-1:0]  block_bytes,
  output logic [SIZE_W-1:0]   stored_size,
  output logic [FREE_W-1:0]   free_blocks,
  output logic                last
);

  cmd_t     cmd;
  dp_stat_t st;

  // sequencer
  fba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // storage and arithmetic
  fba_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .action      (action),
    .file_size   (file_size),
    .slot        (slot),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .slot_out    (slot_out),
    .block       (block),
    .block_bytes (block_bytes),
    .stored_size (stored_size),
    .free_blocks (free_blocks),
    .last        (last)
  );

`ifndef SYNTH
  // free count can never exceed the data area
  a_free_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (free_blocks <= FREE_W'(DBLK_TOTAL)))
    else $error("free block count out of range");

  // no request taken during the bitmap clearing pass
  a_clear_busy: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("request accepted during bitmap clear");

  // one request at a time; action 3 is dropped and leaves the block idle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (action != ACT_NONE)) |=> !in_ready)
    else $error("second request accepted while busy");
`endif

endmodule

>>> hw/rtl/fba_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine for the block allocator.
module fba_ctrl import fba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic [1:0] action,
  output logic     in_ready,
  input  dp_stat_t st,
  output cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_SCAN, S_DECIDE, S_WORD, S_ALLOC, S_COMMIT,
    S_META, S_LIST, S_LEMIT, S_DEL, S_DBLK, S_DCLR, S_ONE
  } state_t;

  state_t  state, state_next;
  status_t code, code_next;
  op_t     op;

  assign in_ready = (state == S_IDLE);
  assign cmd.op   = op;
  assign cmd.code = code;

  always_comb begin
    state_next = state;
    code_next  = code;
    op         = OP_NONE;
    case (state)
      S_CLEAR: begin
        op = OP_CLR;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op = OP_LOAD;
          case (action_t'(action))
            ACT_STORE:  state_next = S_SCAN;
            ACT_DELETE: state_next = S_CHECK;
            ACT_READ:   state_next = S_CHECK;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_CHECK: begin
        if (!st.slot_busy) begin
          code_next  = ST_UNUSED;
          state_next = S_ONE;
        end else begin
          op         = OP_META_RD;
          state_next = S_META;
        end
      end
      S_META: begin
        op         = OP_META_LATCH;
        state_next = (st.act == ACT_DELETE) ? S_DEL : S_LIST;
      end
      S_SCAN: begin
        op = OP_SCAN;
        if (st.scan_last) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (st.over_free) begin
          code_next  = ST_NOSPACE;
          state_next = S_ONE;
        end else if (!st.slot_found) begin
          code_next  = ST_NOSLOT;
          state_next = S_ONE;
        end else if (st.over_limit) begin
          code_next  = ST_TOOBIG;
          state_next = S_ONE;
        end else begin
          op         = OP_WORD_RD;
          state_next = S_WORD;
        end
      end
      S_WORD: begin
        op         = OP_WORD_LOAD;
        state_next = S_ALLOC;
      end
      S_ALLOC: begin
        if (st.alloc_done) begin
          state_next = S_COMMIT;
        end else if (st.word_full) begin
          op         = OP_WORD_NEXT;
          state_next = S_WORD;
        end else begin
          op = OP_ALLOC;
        end
      end
      S_COMMIT: begin
        op         = OP_COMMIT;
        state_next = S_LIST;
      end
      S_LIST: begin
        if (st.list_empty) begin
          code_next  = ST_OK;
          state_next = S_ONE;
        end else begin
          op         = OP_LIST_RD;
          state_next = S_LEMIT;
        end
      end
      S_LEMIT: begin
        if (st.out_free) begin
          op         = OP_EMIT_LIST;
          state_next = st.list_last ? S_IDLE : S_LIST;
        end
      end
      S_DEL: begin
        if (st.list_end) begin
          op         = OP_DEL_END;
          code_next  = ST_OK;
          state_next = S_ONE;
        end else begin
          op         = OP_LIST_RD;
          state_next = S_DBLK;
        end
      end
      S_DBLK: begin
        op         = OP_DBLK_RD;
        state_next = S_DCLR;
      end
      S_DCLR: begin
        op         = OP_DBLK_CLR;
        state_next = S_DEL;
      end
      S_ONE: begin
        if (st.out_free) begin
          op         = OP_EMIT_ONE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      code  <= ST_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

endmodule

>>> hw/rtl/fba_dp.sv
`timescale 1ns / 1ps
// Datapath: bitmap, slot tables, block lists, free count and output register.
module fba_dp import fba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output dp_stat_t            st,
  input  logic [1:0]          action,
  input  logic [SIZE_W-1:0]   file_size,
  input  logic [SLOT_W-1:0]   slot,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic [SLOT_W-1:0]   slot_out,
  output logic [BLK_W-1:0]    block,
  output logic [BYTES_W-1:0]  block_bytes,
  output logic [SIZE_W-1:0]   stored_size,
  output logic [FREE_W-1:0]   free_blocks,
  output logic                last
);

  logic [WORD_W-1:0]         bm_mem [BM_WORDS];
  logic [BLK_W-1:0]          list_mem [2**LIST_AW];
  logic [CNT_W+SIZE_W-1:0]   meta_mem [FILE_SLOTS];

  logic [FILE_SLOTS-1:0]     slot_used;
  logic [FREE_W-1:0]         free_count;
  logic [BM_AW-1:0]          clr_idx;
  action_t                   act;
  logic [SIZE_W-1:0]         size_r;
  logic [SLOT_W-1:0]         slot_r;
  logic [NEED_W-1:0]         need;
  logic [GRP_AW-1:0]         grp;
  logic                      found;
  logic [BM_AW-1:0]          word_idx;
  logic [WORD_W-1:0]         cur_word;
  logic [CNT_W-1:0]          cnt;
  logic [CNT_W-1:0]          n;
  logic [CNT_W-1:0]          idx;
  logic [SIZE_W-1:0]         msize;
  logic [WORD_W-1:0]         bm_q;
  logic [BLK_W-1:0]          list_q;
  logic [CNT_W+SIZE_W-1:0]   meta_q;

  logic [GRP_W-1:0]          grp_bits;
  logic                      grp_hit;
  logic [GRP_BW-1:0]         grp_pos;
  logic [BIT_W-1:0]          zero_pos;
  logic [BM_AW-1:0]          bm_raddr;
  logic                      bm_we;
  logic [BM_AW-1:0]          bm_waddr;
  logic [WORD_W-1:0]         bm_wdata;
  logic                      list_last;
  logic [BLK_W-BIT_W-1:0]    dword;
  logic [BIT_W-1:0]          dbit;
  logic                      store_err;

  assign dword = list_q[BLK_W-1:BIT_W];
  assign dbit  = list_q[BIT_W-1:0];

  // lowest free slot in the current group
  assign grp_bits = slot_used[{grp, {GRP_BW{1'b0}}} +: GRP_W];
  always_comb begin
    grp_hit = 1'b0;
    grp_pos = '0;
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (!grp_bits[i]) begin
        grp_hit = 1'b1;
        grp_pos = GRP_BW'(i);
      end
    end
  end

  // lowest free block in the current bitmap word
  always_comb begin
    zero_pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!cur_word[i]) zero_pos = BIT_W'(i);
    end
  end

  assign list_last = (idx + CNT_W'(1)) == n;

  assign st.clr_last   = (clr_idx == BM_AW'(BM_WORDS - 1));
  assign st.scan_last  = (grp == GRP_AW'(GRP_N - 1));
  assign st.slot_found = found;
  assign st.slot_busy  = slot_used[slot_r];
  assign st.over_free  = FREE_W'(need) > free_count;
  assign st.over_limit = need > NEED_W'(BLOCKS_PER_FILE);
  assign st.word_full  = &cur_word;
  assign st.alloc_done = NEED_W'(cnt) == need;
  assign st.list_empty = (n == '0);
  assign st.list_last  = list_last;
  assign st.list_end   = (idx == n);
  assign st.out_free   = !out_valid || out_ready;
  assign st.act        = act;

  always_comb begin
    bm_raddr = word_idx;
    bm_we    = 1'b0;
    bm_waddr = word_idx;
    bm_wdata = cur_word;
    case (cmd.op)
      OP_CLR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_idx;
        bm_wdata = '0;
      end
      OP_WORD_RD:   bm_raddr = '0;
      OP_WORD_NEXT: begin
        bm_raddr = word_idx + BM_AW'(1);
        bm_we    = 1'b1;
      end
      OP_COMMIT:    bm_we = 1'b1;
      OP_DBLK_RD:   bm_raddr = BM_AW'(dword);
      OP_DBLK_CLR: begin
        bm_we    = bm_q[dbit];
        bm_waddr = BM_AW'(dword);
        bm_wdata = bm_q & ~(WORD_W'(1) << dbit);
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    bm_q <= bm_mem[bm_raddr];
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    if (cmd.op == OP_ALLOC) list_mem[{slot_r, cnt[LIST_AW-SLOT_W-1:0]}] <= {word_idx, zero_pos};
    if (cmd.op == OP_LIST_RD) list_q <= list_mem[{slot_r, idx[LIST_AW-SLOT_W-1:0]}];
    if (cmd.op == OP_COMMIT) meta_mem[slot_r] <= {cnt, size_r};
    if (cmd.op == OP_META_RD) meta_q <= meta_mem[slot_r];
  end

  assign store_err = (cmd.code == ST_NOSPACE) || (cmd.code == ST_NOSLOT) ||
                     (cmd.code == ST_TOOBIG);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used  <= '0;
      free_count <= FREE_W'(DBLK_TOTAL);
      clr_idx    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.op == OP_CLR) clr_idx <= clr_idx + BM_AW'(1);
      if (cmd.op == OP_COMMIT) begin
        slot_used[slot_r] <= 1'b1;
        free_count        <= free_count - FREE_W'(cnt);
      end
      if (cmd.op == OP_DBLK_CLR && bm_q[dbit]) free_count <= free_count + FREE_W'(1);
      if (cmd.op == OP_DEL_END) slot_used[slot_r] <= 1'b0;
      if (cmd.op == OP_EMIT_LIST || cmd.op == OP_EMIT_ONE) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // working registers and output beat
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        act    <= action_t'(action);
        size_r <= file_size;
        slot_r <= slot;
        need   <= NEED_W'(({1'b0, file_size} + (SIZE_W + 1)'(BLOCK_BYTES - 1)) >> BB_SH);
        grp    <= '0;
        found  <= 1'b0;
      end
      OP_SCAN: begin
        grp <= grp + GRP_AW'(1);
        if (!found && grp_hit) begin
          found  <= 1'b1;
          slot_r <= {grp, grp_pos};
        end
      end
      OP_WORD_RD: begin
        word_idx <= '0;
        cnt      <= '0;
      end
      OP_WORD_LOAD: cur_word <= bm_q;
      OP_ALLOC: begin
        cur_word[zero_pos] <= 1'b1;
        cnt                <= cnt + CNT_W'(1);
      end
      OP_WORD_NEXT: word_idx <= word_idx + BM_AW'(1);
      OP_COMMIT: begin
        n     <= cnt;
        msize <= size_r;
        idx   <= '0;
      end
      OP_META_LATCH: begin
        n     <= meta_q[CNT_W+SIZE_W-1:SIZE_W];
        msize <= meta_q[SIZE_W-1:0];
        idx   <= '0;
      end
      OP_DBLK_CLR: idx <= idx + CNT_W'(1);
      OP_EMIT_LIST: begin
        idx         <= idx + CNT_W'(1);
        status      <= ST_OK;
        slot_out    <= slot_r;
        block       <= list_q;
        block_bytes <= list_last ? BYTES_W'(msize - (SIZE_W'(idx) << BB_SH))
                                 : BYTES_W'(BLOCK_BYTES);
        stored_size <= msize;
        free_blocks <= free_count;
        last        <= list_last;
      end
      OP_EMIT_ONE: begin
        status      <= cmd.code;
        slot_out    <= store_err ? '0 : slot_r;
        block       <= '0;
        block_bytes <= '0;
        stored_size <= (cmd.code == ST_OK) ? msize : '0;
        free_blocks <= free_count;
        last        <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule
